@@ hdl/pafxy_pkg.sv @@
// shared constants and the arctangent table for the polar angle unit
package pafxy_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF  = 16;
    localparam int PRESCALE_BITS   = 24;
    localparam int GUARD_BITS      = 3;
    localparam int Z_WIDTH         = 35;
    localparam int TAB_WIDTH       = 30;
    localparam int ANGLE_WIDTH     = 16;
    localparam int ROUND_SHIFT     = 17;
    localparam int Q_WIDTH         = Z_WIDTH - ROUND_SHIFT;

    localparam logic signed [Z_WIDTH-1:0] PI_Q30     = 35'sd3373259426;
    localparam logic signed [Z_WIDTH-1:0] TWO_PI_Q30 = 35'sd6746518852;
    localparam logic signed [Z_WIDTH-1:0] ROUND_HALF = 35'sd65536;
    localparam logic [Q_WIDTH-1:0]        TWO_PI_Q13 = 18'd51472;

    function automatic logic [TAB_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [TAB_WIDTH-1:0] v;
        case (idx)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            5'd24:   v = 30'h0000003F;
            5'd25:   v = 30'h0000001F;
            5'd26:   v = 30'h0000000F;
            5'd27:   v = 30'h00000008;
            5'd28:   v = 30'h00000004;
            5'd29:   v = 30'h00000002;
            5'd30:   v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/pafxy_if.sv @@
// channel interfaces for coordinate pairs and angle results
interface pafxy_pt_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface pafxy_ang_if;
    logic        valid;
    logic        ready;
    logic [15:0] angle;
    logic        origin_flag;

    modport source (output valid, output angle, output origin_flag, input ready);
    modport sink   (input valid, input angle, input origin_flag, output ready);
endinterface

@@ hdl/pafxy_prep.sv @@
// input stage: sign extension, prescale, left half-plane fold, origin detect
module pafxy_prep
    import pafxy_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int DW          = COORD_WIDTH_DEF + PRESCALE_BITS + GUARD_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output logic signed [DW-1:0]          x_out,
    output logic signed [DW-1:0]          y_out,
    output logic signed [Z_WIDTH-1:0]     z_out,
    output logic                          org_out
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      y_reg;
    logic signed [Z_WIDTH-1:0] z_reg;
    logic                      org_reg;
    logic signed [DW-1:0]      x_sc;
    logic signed [DW-1:0]      y_sc;
    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_next;
    logic signed [Z_WIDTH-1:0] z_next;
    logic                      org_next;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        x_sc     = {{(DW-COORD_WIDTH){x_coord[COORD_WIDTH-1]}}, x_coord} <<< PRESCALE_BITS;
        y_sc     = {{(DW-COORD_WIDTH){y_coord[COORD_WIDTH-1]}}, y_coord} <<< PRESCALE_BITS;
        org_next = (x_coord == '0) && (y_coord == '0);
        if (x_coord[COORD_WIDTH-1])
        begin
            x_next = -x_sc;
            y_next = -y_sc;
            z_next = PI_Q30;
        end
        else
        begin
            x_next = x_sc;
            y_next = y_sc;
            z_next = '0;
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            org_reg <= org_next;
        end
    end

    assign dn_valid = valid_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign org_out  = org_reg;

endmodule

@@ hdl/pafxy_cell.sv @@
// one cordic vectoring step with its own pipeline register
module pafxy_cell
    import pafxy_pkg::*;
#(
    parameter int DW   = COORD_WIDTH_DEF + PRESCALE_BITS + GUARD_BITS,
    parameter int STEP = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic signed [DW-1:0]      x_in,
    input  logic signed [DW-1:0]      y_in,
    input  logic signed [Z_WIDTH-1:0] z_in,
    input  logic                      org_in,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic signed [DW-1:0]      x_out,
    output logic signed [DW-1:0]      y_out,
    output logic signed [Z_WIDTH-1:0] z_out,
    output logic                      org_out
);

    localparam logic [4:0] IDX = 5'(STEP);
    localparam logic signed [Z_WIDTH-1:0] STEP_ANGLE =
        signed'({{(Z_WIDTH-TAB_WIDTH){1'b0}}, atan_entry(IDX)});

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [DW-1:0]      x_reg;
    logic signed [DW-1:0]      y_reg;
    logic signed [Z_WIDTH-1:0] z_reg;
    logic                      org_reg;
    logic signed [DW-1:0]      x_next;
    logic signed [DW-1:0]      y_next;
    logic signed [Z_WIDTH-1:0] z_next;
    logic signed [DW-1:0]      xs;
    logic signed [DW-1:0]      ys;
    logic                      y_pos;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        xs    = x_in >>> STEP;
        ys    = y_in >>> STEP;
        y_pos = !y_in[DW-1] && (y_in != '0);
        if (y_pos)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + STEP_ANGLE;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - STEP_ANGLE;
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            org_reg <= org_in;
        end
    end

    assign dn_valid = valid_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign org_out  = org_reg;

endmodule

@@ hdl/pafxy_round.sv @@
// output stage: fold into [0, 2*pi), round to q3.13, wrap, origin override
module pafxy_round
    import pafxy_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      up_valid,
    output logic                      up_ready,
    input  logic signed [Z_WIDTH-1:0] z_in,
    input  logic                      org_in,
    output logic                      dn_valid,
    input  logic                      dn_ready,
    output logic [ANGLE_WIDTH-1:0]    angle,
    output logic                      origin_flag
);

    logic                      valid_reg;
    logic                      valid_next;
    logic [ANGLE_WIDTH-1:0]    angle_reg;
    logic [ANGLE_WIDTH-1:0]    angle_next;
    logic                      org_reg;
    logic signed [Z_WIDTH-1:0] z_fold;
    logic signed [Z_WIDTH-1:0] z_sum;
    logic [Q_WIDTH-1:0]        q;

    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        z_fold = z_in;
        if (z_fold < 0)
        begin
            z_fold = z_fold + TWO_PI_Q30;
        end
        if (z_fold < 0)
        begin
            z_fold = '0;
        end
        z_sum = z_fold + ROUND_HALF;
        q     = z_sum[Z_WIDTH-1:ROUND_SHIFT];
        if (org_in || (q >= TWO_PI_Q13))
        begin
            angle_next = '0;
        end
        else
        begin
            angle_next = q[ANGLE_WIDTH-1:0];
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            angle_reg <= angle_next;
            org_reg   <= org_in;
        end
    end

    assign dn_valid    = valid_reg;
    assign angle       = angle_reg;
    assign origin_flag = org_reg;

endmodule

@@ hdl/polar_angle_from_xy.sv @@
// top level: pipelined cordic atan2 giving the polar angle of (x, y)
//
//   channel  | dir | contents                     | handshake
//   ---------+-----+------------------------------+-------------
//   point    | in  | x_coord, y_coord             | valid/ready
//   result   | out | angle (q3.13 rad), origin_flag | valid/ready
//
// one transfer per clock sustained while result.ready stays high; the stages are
// the input stage, one cordic cell per iteration and the rounding/output stage
// each stage holds its item under a stall and takes a new one once its
// successor has room, so the pipeline fills even while the output waits
// reset (rst_n, async, active low) clears only the stage valid bits
module polar_angle_from_xy
    import pafxy_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int ITERATIONS  = ITERATIONS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pafxy_pt_if.sink    point,
    pafxy_ang_if.source result
);

    localparam int DW = COORD_WIDTH + PRESCALE_BITS + GUARD_BITS;

    logic                      stg_valid [ITERATIONS+1];
    logic                      stg_ready [ITERATIONS+1];
    logic signed [DW-1:0]      stg_x     [ITERATIONS+1];
    logic signed [DW-1:0]      stg_y     [ITERATIONS+1];
    logic signed [Z_WIDTH-1:0] stg_z     [ITERATIONS+1];
    logic                      stg_org   [ITERATIONS+1];

    pafxy_prep #(
        .COORD_WIDTH (COORD_WIDTH),
        .DW          (DW)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (point.valid),
        .up_ready (point.ready),
        .x_coord  (point.x_coord),
        .y_coord  (point.y_coord),
        .dn_valid (stg_valid[0]),
        .dn_ready (stg_ready[0]),
        .x_out    (stg_x[0]),
        .y_out    (stg_y[0]),
        .z_out    (stg_z[0]),
        .org_out  (stg_org[0])
    );

    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_cell
        pafxy_cell #(
            .DW   (DW),
            .STEP (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stg_valid[i]),
            .up_ready (stg_ready[i]),
            .x_in     (stg_x[i]),
            .y_in     (stg_y[i]),
            .z_in     (stg_z[i]),
            .org_in   (stg_org[i]),
            .dn_valid (stg_valid[i+1]),
            .dn_ready (stg_ready[i+1]),
            .x_out    (stg_x[i+1]),
            .y_out    (stg_y[i+1]),
            .z_out    (stg_z[i+1]),
            .org_out  (stg_org[i+1])
        );
    end

    pafxy_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (stg_valid[ITERATIONS]),
        .up_ready    (stg_ready[ITERATIONS]),
        .z_in        (stg_z[ITERATIONS]),
        .org_in      (stg_org[ITERATIONS]),
        .dn_valid    (result.valid),
        .dn_ready    (result.ready),
        .angle       (result.angle),
        .origin_flag (result.origin_flag)
    );

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.angle < 16'd51472))
        else $error("angle outside [0, 2*pi)");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.origin_flag) |-> (result.angle == '0))
        else $error("origin result with nonzero angle");

    a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !stg_valid[0] |-> point.ready)
        else $error("empty input stage refuses a transfer");

    a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid[ITERATIONS] && !stg_ready[ITERATIONS]) |=> stg_valid[ITERATIONS])
        else $error("last cordic stage dropped a stalled item");

endmodule
